### rtl/ready_blocked_process_queues_defines.svh
// assertion macros for the ready/blocked process queues
`ifndef READY_BLOCKED_PROCESS_QUEUES_DEFINES_SVH
`define READY_BLOCKED_PROCESS_QUEUES_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define RBPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbpq assertion failed");
// next-cycle implication, disabled while in reset
`define RBPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbpq assertion failed");
`else
`define RBPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RBPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/rbpq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ready/blocked process queues
package rbpq_pkg;

    localparam int READY_DEPTH   = 16;
    localparam int BLOCKED_DEPTH = 16;

    localparam int RDY_IDX_W = $clog2(READY_DEPTH);
    localparam int RDY_CNT_W = $clog2(READY_DEPTH + 1);
    localparam int RDY_SUM_W = $clog2(2 * READY_DEPTH);
    localparam int BLK_IDX_W = $clog2(BLOCKED_DEPTH);
    localparam int BLK_CNT_W = $clog2(BLOCKED_DEPTH + 1);
    localparam int BLK_SUM_W = $clog2(2 * BLOCKED_DEPTH);

    localparam int NAME_W  = 8;
    localparam int COUNT_W = 5;

    typedef enum logic [2:0] {
        OP_CREATE    = 3'd0,
        OP_DISPATCH  = 3'd1,
        OP_END       = 3'd2,
        OP_BLOCK     = 3'd3,
        OP_WAKE      = 3'd4,
        OP_TIMESLICE = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_READY_EMPTY   = 3'd1,
        ST_CPU_BUSY      = 3'd2,
        ST_BLOCKED_EMPTY = 3'd3,
        ST_CPU_IDLE      = 3'd4,
        ST_TARGET_FULL   = 3'd5
    } t_status;

    typedef struct packed {
        t_opcode           opcode;
        logic [NAME_W-1:0] proc_name;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [NAME_W-1:0]  moved_name;
        logic               cpu_busy;
        logic [NAME_W-1:0]  running_name;
        logic [COUNT_W-1:0] ready_count;
        logic [COUNT_W-1:0] blocked_count;
    } t_result;

endpackage

### rtl/rbpq_if.sv
`timescale 1ns / 1ps
// handshake channels for commands and results
interface rbpq_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] proc_name;

    modport source (output valid, output opcode, output proc_name, input ready);
    modport sink (input valid, input opcode, input proc_name, output ready);
endinterface

interface rbpq_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] moved_name;
    logic       cpu_busy;
    logic [7:0] running_name;
    logic [4:0] ready_count;
    logic [4:0] blocked_count;

    modport source (
        output valid, output status, output moved_name, output cpu_busy,
        output running_name, output ready_count, output blocked_count,
        input ready
    );
    modport sink (
        input valid, input status, input moved_name, input cpu_busy,
        input running_name, input ready_count, input blocked_count,
        output ready
    );
endinterface

### rtl/rbpq_core.sv
`timescale 1ns / 1ps
// queue state, running slot and the per-command update logic
`include "ready_blocked_process_queues_defines.svh"

module rbpq_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  rbpq_pkg::t_cmd   i_cmd,
    output rbpq_pkg::t_result o_res
);

    localparam int RIW = rbpq_pkg::RDY_IDX_W;
    localparam int RCW = rbpq_pkg::RDY_CNT_W;
    localparam int RSW = rbpq_pkg::RDY_SUM_W;
    localparam int BIW = rbpq_pkg::BLK_IDX_W;
    localparam int BCW = rbpq_pkg::BLK_CNT_W;
    localparam int BSW = rbpq_pkg::BLK_SUM_W;
    localparam int NW  = rbpq_pkg::NAME_W;

    logic [NW-1:0]  r_rdy_mem [rbpq_pkg::READY_DEPTH];
    logic [NW-1:0]  r_blk_mem [rbpq_pkg::BLOCKED_DEPTH];
    logic [RIW-1:0] r_rdy_head, n_rdy_head;
    logic [RCW-1:0] r_rdy_fill, n_rdy_fill;
    logic [BIW-1:0] r_blk_head, n_blk_head;
    logic [BCW-1:0] r_blk_fill, n_blk_fill;
    logic [NW-1:0]  r_slot_name, n_slot_name;
    logic           r_slot_valid, n_slot_valid;

    logic           rdy_full, rdy_empty, blk_full, blk_empty;
    logic [RSW-1:0] rdy_sum;
    logic [BSW-1:0] blk_sum;
    logic [RIW-1:0] rdy_tail;
    logic [BIW-1:0] blk_tail;
    logic [NW-1:0]  rdy_head_data, blk_head_data;
    logic           rdy_push, rdy_pop, blk_push, blk_pop;
    logic [NW-1:0]  rdy_push_data;
    rbpq_pkg::t_status status;
    logic [NW-1:0]  moved;

    assign rdy_full  = (r_rdy_fill == RCW'(rbpq_pkg::READY_DEPTH));
    assign rdy_empty = (r_rdy_fill == '0);
    assign blk_full  = (r_blk_fill == BCW'(rbpq_pkg::BLOCKED_DEPTH));
    assign blk_empty = (r_blk_fill == '0);

    // tail = (head + fill) wrapped once at the depth
    assign rdy_sum  = RSW'(r_rdy_head) + RSW'(r_rdy_fill);
    assign blk_sum  = BSW'(r_blk_head) + BSW'(r_blk_fill);
    assign rdy_tail = (rdy_sum >= RSW'(rbpq_pkg::READY_DEPTH))
                    ? RIW'(rdy_sum - RSW'(rbpq_pkg::READY_DEPTH)) : RIW'(rdy_sum);
    assign blk_tail = (blk_sum >= BSW'(rbpq_pkg::BLOCKED_DEPTH))
                    ? BIW'(blk_sum - BSW'(rbpq_pkg::BLOCKED_DEPTH)) : BIW'(blk_sum);

    assign rdy_head_data = r_rdy_mem[r_rdy_head];
    assign blk_head_data = r_blk_mem[r_blk_head];

    always_comb begin
        status        = rbpq_pkg::ST_OK;
        moved         = '0;
        rdy_push      = 1'b0;
        rdy_pop       = 1'b0;
        blk_push      = 1'b0;
        blk_pop       = 1'b0;
        rdy_push_data = i_cmd.proc_name;
        n_slot_valid  = r_slot_valid;
        n_slot_name   = r_slot_name;
        case (i_cmd.opcode)
            rbpq_pkg::OP_CREATE: begin
                if (rdy_full) begin
                    status = rbpq_pkg::ST_TARGET_FULL;
                end else begin
                    rdy_push = 1'b1;
                    moved    = i_cmd.proc_name;
                end
            end
            rbpq_pkg::OP_DISPATCH: begin
                if (r_slot_valid) begin
                    status = rbpq_pkg::ST_CPU_BUSY;
                end else if (rdy_empty) begin
                    status = rbpq_pkg::ST_READY_EMPTY;
                end else begin
                    rdy_pop      = 1'b1;
                    n_slot_valid = 1'b1;
                    n_slot_name  = rdy_head_data;
                    moved        = rdy_head_data;
                end
            end
            rbpq_pkg::OP_END: begin
                if (r_slot_valid) begin
                    moved        = r_slot_name;
                    n_slot_valid = 1'b0;
                    n_slot_name  = '0;
                end
            end
            rbpq_pkg::OP_BLOCK: begin
                if (!r_slot_valid) begin
                    status = rbpq_pkg::ST_CPU_IDLE;
                end else if (blk_full) begin
                    status = rbpq_pkg::ST_TARGET_FULL;
                end else begin
                    blk_push     = 1'b1;
                    moved        = r_slot_name;
                    n_slot_valid = 1'b0;
                    n_slot_name  = '0;
                end
            end
            rbpq_pkg::OP_TIMESLICE: begin
                if (!r_slot_valid) begin
                    status = rbpq_pkg::ST_CPU_IDLE;
                end else if (rdy_full) begin
                    status = rbpq_pkg::ST_TARGET_FULL;
                end else begin
                    rdy_push      = 1'b1;
                    rdy_push_data = r_slot_name;
                    moved         = r_slot_name;
                    n_slot_valid  = 1'b0;
                    n_slot_name   = '0;
                end
            end
            rbpq_pkg::OP_WAKE: begin
                if (blk_empty) begin
                    status = rbpq_pkg::ST_BLOCKED_EMPTY;
                end else if (rdy_full) begin
                    status = rbpq_pkg::ST_TARGET_FULL;
                end else begin
                    blk_pop       = 1'b1;
                    rdy_push      = 1'b1;
                    rdy_push_data = blk_head_data;
                    moved         = blk_head_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_rdy_fill = r_rdy_fill + RCW'(rdy_push) - RCW'(rdy_pop);
        n_blk_fill = r_blk_fill + BCW'(blk_push) - BCW'(blk_pop);
        n_rdy_head = r_rdy_head;
        n_blk_head = r_blk_head;
        if (rdy_pop) begin
            n_rdy_head = (r_rdy_head == RIW'(rbpq_pkg::READY_DEPTH - 1))
                       ? '0 : r_rdy_head + 1'b1;
        end
        if (blk_pop) begin
            n_blk_head = (r_blk_head == BIW'(rbpq_pkg::BLOCKED_DEPTH - 1))
                       ? '0 : r_blk_head + 1'b1;
        end
    end

    // result reflects the state after the command
    assign o_res.status        = status;
    assign o_res.moved_name    = moved;
    assign o_res.cpu_busy      = n_slot_valid;
    assign o_res.running_name  = n_slot_valid ? n_slot_name : '0;
    assign o_res.ready_count   = rbpq_pkg::COUNT_W'(n_rdy_fill);
    assign o_res.blocked_count = rbpq_pkg::COUNT_W'(n_blk_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy_head   <= '0;
            r_rdy_fill   <= '0;
            r_blk_head   <= '0;
            r_blk_fill   <= '0;
            r_slot_name  <= '0;
            r_slot_valid <= 1'b0;
        end else if (i_step) begin
            r_rdy_head   <= n_rdy_head;
            r_rdy_fill   <= n_rdy_fill;
            r_blk_head   <= n_blk_head;
            r_blk_fill   <= n_blk_fill;
            r_slot_name  <= n_slot_name;
            r_slot_valid <= n_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && rdy_push) begin
            r_rdy_mem[rdy_tail] <= rdy_push_data;
        end
        if (i_step && blk_push) begin
            r_blk_mem[blk_tail] <= r_slot_name;
        end
    end

    `RBPQ_ASSERT_IMPL(a_rdy_fill_bound, i_clk, i_rst_n, 1'b1, r_rdy_fill <= RCW'(rbpq_pkg::READY_DEPTH))
    `RBPQ_ASSERT_IMPL(a_blk_fill_bound, i_clk, i_rst_n, 1'b1, r_blk_fill <= BCW'(rbpq_pkg::BLOCKED_DEPTH))
    `RBPQ_ASSERT_IMPL(a_idle_slot_clear, i_clk, i_rst_n, !r_slot_valid, r_slot_name == '0)
    `RBPQ_ASSERT_NEXT(a_create_grows, i_clk, i_rst_n, i_step && i_cmd.opcode == rbpq_pkg::OP_CREATE && !rdy_full, r_rdy_fill == $past(r_rdy_fill) + 1'b1)
    `RBPQ_ASSERT_NEXT(a_dispatch_fills, i_clk, i_rst_n, i_step && i_cmd.opcode == rbpq_pkg::OP_DISPATCH && !r_slot_valid && !rdy_empty, r_slot_valid)

endmodule

### rtl/ready_blocked_process_queues.sv
`timescale 1ns / 1ps
// top level of the ready/blocked process queues with one running slot
//
// i_cmd carries one command per transfer (opcode, proc_name); o_res returns
// exactly one result per command, in order (status, moved name, slot
// contents and both queue counts after the command).
// a command is taken into an input register, applied to the queues and
// the slot when it leaves that register, and its result lands in an output
// register that drives o_res.valid.
// throughput is one command per cycle while o_res.ready is high; each
// command updates the queue pointers, fill counts and slot in a single
// register update, and the next command sees that state in its own cycle.
// when the receiver holds o_res.ready low the result waits in the output
// register, one more command waits in the input register, and then
// i_cmd.ready drops until the result is taken.
// reset empties both queues and the slot; queue entries keep no reset value
// and are only read after they were written.
module ready_blocked_process_queues (
    input logic        i_clk,
    input logic        i_rst_n,
    rbpq_cmd_if.sink   i_cmd,
    rbpq_res_if.source o_res
);

    logic              r_s1_valid;
    rbpq_pkg::t_cmd    r_s1_cmd;
    logic              r_s2_valid;
    rbpq_pkg::t_result r_s2_res;
    rbpq_pkg::t_result core_res;
    rbpq_pkg::t_cmd    in_cmd;
    logic              advance;

    assign advance     = r_s1_valid && (!r_s2_valid || o_res.ready);
    assign i_cmd.ready = !r_s1_valid || advance;

    assign in_cmd.opcode    = rbpq_pkg::t_opcode'(i_cmd.opcode);
    assign in_cmd.proc_name = i_cmd.proc_name;

    rbpq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cmd   (r_s1_cmd),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_s1_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_s2_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_s1_cmd <= in_cmd;
        end
        if (advance) begin
            r_s2_res <= core_res;
        end
    end

    assign o_res.valid         = r_s2_valid;
    assign o_res.status        = r_s2_res.status;
    assign o_res.moved_name    = r_s2_res.moved_name;
    assign o_res.cpu_busy      = r_s2_res.cpu_busy;
    assign o_res.running_name  = r_s2_res.running_name;
    assign o_res.ready_count   = r_s2_res.ready_count;
    assign o_res.blocked_count = r_s2_res.blocked_count;

endmodule
